>>> hw/rtl/sts_pkg.sv
// shared types and constants for the sorted table search block
`timescale 1ns / 1ps

package sts_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_W           = 32;
    localparam int SLOT_W          = 10;
    localparam int COUNT_W         = 11;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic init;
        logic load_ends;
        logic probe;
        logic step;
        logic out_load;
        logic out_found;
    } t_ctrl;

    typedef struct packed {
        logic empty;
        logic outside;
        logic hit_end;
        logic hit_mid;
        logic out_free;
    } t_stat;

endpackage

>>> hw/rtl/sts_dp.sv
// datapath of the sorted table search: key memory, range registers and result register
`timescale 1ns / 1ps

module sts_dp #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sts_pkg::COUNT_W-1:0]         i_cfg_data,
    input  logic [sts_pkg::SLOT_W-1:0]          i_slot,
    input  logic signed [sts_pkg::KEY_W-1:0]    i_key,
    input  logic                                i_out_stall,
    input  sts_pkg::t_ctrl                      i_ctrl,
    output sts_pkg::t_stat                      o_stat,
    output logic                                o_out_valid,
    output logic                                o_found
);
    import sts_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic signed [KEY_W-1:0] mem [TABLE_DEPTH];

    logic [COUNT_W-1:0]      r_count;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic [CW-1:0]           r_mid;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_first, n_first;
    logic signed [KEY_W-1:0] r_last, n_last;
    logic signed [KEY_W-1:0] r_rd_a;
    logic signed [KEY_W-1:0] r_rd_b;
    logic                    r_out_valid;
    logic                    r_found;

    logic [CW-1:0]           sat_count;
    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid;
    logic [AW-1:0]           addr_a;
    logic [AW-1:0]           addr_b;
    logic                    slot_ok;

    // entry count clipped to the table depth
    always_comb begin
        if (32'(r_count) > 32'(TABLE_DEPTH)) begin
            sat_count = CW'(TABLE_DEPTH);
        end else begin
            sat_count = CW'(r_count);
        end
    end

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign slot_ok = 32'(i_slot) < 32'(TABLE_DEPTH);

    always_comb begin
        if (i_ctrl.init) begin
            addr_a = '0;
            addr_b = AW'(sat_count - 1'b1);
        end else begin
            addr_a = AW'(mid);
            addr_b = AW'(mid - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en && slot_ok) begin
            mem[AW'(i_slot)] <= i_key;
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_first = r_first;
        n_last  = r_last;
        if (i_ctrl.init) begin
            n_lo = '0;
            n_hi = sat_count;
        end else if (i_ctrl.load_ends) begin
            n_first = r_rd_a;
            n_last  = r_rd_b;
        end else if (i_ctrl.step) begin
            if (r_key < r_rd_a) begin
                n_hi   = r_mid;
                n_last = r_rd_b;
            end else begin
                n_lo    = r_mid;
                n_first = r_rd_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_first <= n_first;
        r_last  <= n_last;
        if (i_ctrl.init) begin
            r_key <= i_key;
        end
        if (i_ctrl.probe) begin
            r_mid <= mid;
        end
        if (i_ctrl.out_load) begin
            r_found <= i_ctrl.out_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.empty    = r_lo >= r_hi;
    assign o_stat.outside  = (r_key < r_first) || (r_key > r_last);
    assign o_stat.hit_end  = (r_key == r_first) || (r_key == r_last);
    assign o_stat.hit_mid  = r_key == r_rd_a;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

`ifndef SYNTHESIS
    a_probe_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.probe |-> (mid > r_lo) && (mid < r_hi))
        else $error("midpoint outside the open range");

    a_step_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.step |=> (r_hi - r_lo) < $past(r_hi - r_lo))
        else $error("search range did not shrink");

    a_step_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.step |=> r_lo < r_hi)
        else $error("search range became empty after a step");
`endif

endmodule

>>> hw/rtl/sts_ctrl.sv
// controller state machine of the sorted table search
`timescale 1ns / 1ps

module sts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_cmd,
    output logic           o_in_stall,
    input  sts_pkg::t_stat i_stat,
    output sts_pkg::t_ctrl o_ctrl
);
    import sts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ENDS  = 5'b00010,
        S_CHECK = 5'b00100,
        S_MID   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_result, n_result;
    logic   accept;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        n_state  = r_state;
        n_result = r_result;
        o_ctrl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_SEARCH) begin
                        o_ctrl.init = 1'b1;
                        n_state     = S_ENDS;
                    end else begin
                        o_ctrl.wr_en = 1'b1;
                    end
                end
            end
            S_ENDS: begin
                o_ctrl.load_ends = 1'b1;
                n_state          = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.empty || i_stat.outside) begin
                    n_result = 1'b0;
                    n_state  = S_DONE;
                end else if (i_stat.hit_end) begin
                    n_result = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    o_ctrl.probe = 1'b1;
                    n_state      = S_MID;
                end
            end
            S_MID: begin
                if (i_stat.hit_mid) begin
                    n_result = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    o_ctrl.step = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load  = 1'b1;
                    o_ctrl.out_found = r_result;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.out_load |-> i_stat.out_free)
        else $error("result loaded over a pending transaction");

    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_SEARCH)) |=> (r_state == S_ENDS))
        else $error("search transaction did not start a lookup");
`endif

endmodule

>>> hw/rtl/sorted_table_binary_search.sv
// top level of the sorted table search: key table with binary lookup
// search: the endpoints are read and checked first, then up to ceil(log2(TABLE_DEPTH))
//   probes halve the range until a hit or an empty range; writes complete in the idle state
// flow: one transaction at a time; a search holds the input until its result is loaded,
//   with a memory read state and a compare state per probe, plus any result stall
// reset: synchronous active low, clears the entry count and control state; table undefined
`timescale 1ns / 1ps

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sts_pkg::COUNT_W-1:0]      i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic [sts_pkg::SLOT_W-1:0]       i_slot,
    input  logic signed [sts_pkg::KEY_W-1:0] i_key,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_found
);
    import sts_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    sts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    sts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_slot      (i_slot),
        .i_key       (i_key),
        .i_out_stall (i_out_stall),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_found     (o_found)
    );

endmodule
